>>> rtl/ecol_pkg.sv
// Shared widths and pipeline record types for the elastic collision datapath.
package ecol_pkg;

  localparam int MW  = 16;        // mass width
  localparam int SW  = MW + 1;    // mass sum width
  localparam int VW  = 32;        // Q16.16 word
  localparam int DFW = VW + 1;    // difference width
  localparam int PW  = 2 * DFW;   // product of two differences
  localparam int TW  = PW + DFW;  // dot magnitude times a difference
  localparam int DW  = PW + SW;   // divisor width
  localparam int NW  = TW + SW;   // numerator width
  localparam int QW  = 35;        // quotient bits
  localparam int NL  = 4;         // correction terms per item

  typedef struct packed {
    logic                 valid;
    logic [MW-1:0]        ma;
    logic [MW-1:0]        mb;
    logic [SW-1:0]        msum;
    logic signed [VW-1:0] vax;
    logic signed [VW-1:0] vay;
    logic signed [VW-1:0] vbx;
    logic signed [VW-1:0] vby;
    logic [DFW-1:0]       adx;
    logic [DFW-1:0]       ady;
    logic                 neg_x;
    logic                 neg_y;
    logic                 dvx_neg;
    logic                 dvy_neg;
    logic                 dot_neg;
    logic                 coinc;
    logic                 bypass;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic [DW-1:0]          den;
    logic [NL-1:0][DW-1:0]  rem;
    logic [NL-1:0][QW-1:0]  low;
    logic [NL-1:0][QW-1:0]  q;
  } div_t;

endpackage

>>> rtl/elastic_collision_2d.sv
// Top level of the pipelined two-body elastic collision datapath.
// Usage: drive the ten input fields and pulse start; an item is taken at every
// rising edge where start is high and busy is low. busy is held low, so one
// item may be started in every cycle and the block sustains one item a cycle.
// Each item yields exactly one result: the four new velocities and the
// coincident flag, shown for a single cycle with done high. The result of an
// item passes the stage 1 registers, the first multiplier stage, the stage 4
// registers, the second and third multiplier stages, 35 division cells of one
// quotient bit each, and the output register. Results leave in acceptance order.
// The receiver cannot stall the block, so no back-pressure exists inside it.
// A synchronous reset clears every valid flag in the pipeline and done; any
// items in flight are dropped. When the positions coincide, or both masses
// are zero, the velocities pass through unchanged; coincident reports only
// whether the positions are equal. New velocities saturate to 32 bits.
module elastic_collision_2d import ecol_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [MW-1:0]        mass_a,
  input  logic [MW-1:0]        mass_b,
  input  logic signed [VW-1:0] pos_ax,
  input  logic signed [VW-1:0] pos_ay,
  input  logic signed [VW-1:0] pos_bx,
  input  logic signed [VW-1:0] pos_by,
  input  logic signed [VW-1:0] vel_ax,
  input  logic signed [VW-1:0] vel_ay,
  input  logic signed [VW-1:0] vel_bx,
  input  logic signed [VW-1:0] vel_by,
  output logic                 done,
  output logic signed [VW-1:0] new_vel_ax,
  output logic signed [VW-1:0] new_vel_ay,
  output logic signed [VW-1:0] new_vel_bx,
  output logic signed [VW-1:0] new_vel_by,
  output logic                 coincident
);

  // The datapath never stalls, so the block is always ready for an item.
  assign busy = 1'b0;

  // Stage 1: position and velocity differences, split into sign and magnitude.
  logic signed [DFW-1:0] dx, dy, dvx, dvy;
  side_t                 s1_next, s1;
  logic [DFW-1:0]        advx, advy;

  always_comb begin
    dx  = DFW'(pos_ax) - DFW'(pos_bx);
    dy  = DFW'(pos_ay) - DFW'(pos_by);
    dvx = DFW'(vel_ax) - DFW'(vel_bx);
    dvy = DFW'(vel_ay) - DFW'(vel_by);
    // Nothing enters the pipeline while reset is held.
    s1_next.valid   = start & ~busy & ~rst;
    s1_next.ma      = mass_a;
    s1_next.mb      = mass_b;
    s1_next.msum    = SW'(mass_a) + SW'(mass_b);
    s1_next.vax     = vel_ax;
    s1_next.vay     = vel_ay;
    s1_next.vbx     = vel_bx;
    s1_next.vby     = vel_by;
    s1_next.adx     = dx[DFW-1] ? DFW'(-dx) : DFW'(dx);
    s1_next.ady     = dy[DFW-1] ? DFW'(-dy) : DFW'(dy);
    s1_next.neg_x   = dx[DFW-1];
    s1_next.neg_y   = dy[DFW-1];
    s1_next.dvx_neg = dvx[DFW-1];
    s1_next.dvy_neg = dvy[DFW-1];
    s1_next.dot_neg = 1'b0;
    s1_next.coinc   = (dx == '0) && (dy == '0);
    s1_next.bypass  = s1_next.coinc || (s1_next.msum == '0);
  end

  always_ff @(posedge clk) begin
    s1   <= s1_next;
    advx <= dvx[DFW-1] ? DFW'(-dvx) : DFW'(dvx);
    advy <= dvy[DFW-1] ? DFW'(-dvy) : DFW'(dvy);
  end

  // Stages 2 and 3: the two squares and two cross products of the differences.
  logic [PW-1:0] px, py, nx, ny;
  side_t         s2a, s2;

  ecol_mul #(.AW(DFW), .BW(DFW)) u_mul_px (.clk(clk), .a(advx), .b(s1.adx), .p(px));
  ecol_mul #(.AW(DFW), .BW(DFW)) u_mul_py (.clk(clk), .a(advy), .b(s1.ady), .p(py));
  ecol_mul #(.AW(DFW), .BW(DFW)) u_mul_nx (.clk(clk), .a(s1.adx), .b(s1.adx), .p(nx));
  ecol_mul #(.AW(DFW), .BW(DFW)) u_mul_ny (.clk(clk), .a(s1.ady), .b(s1.ady), .p(ny));

  always_ff @(posedge clk) begin
    if (rst) begin
      s2a <= '0;
      s2  <= '0;
    end else begin
      s2a <= s1;
      s2  <= s2a;
    end
  end

  // Stage 4: signed dot product as sign and magnitude, and the squared distance.
  logic          n1, n2;
  side_t         s3_next, s3;
  logic [PW-1:0] dot_mag_next, dot_mag, norm;

  always_comb begin
    n1      = s2.dvx_neg ^ s2.neg_x;
    n2      = s2.dvy_neg ^ s2.neg_y;
    s3_next = s2;
    if (n1 == n2) begin
      s3_next.dot_neg = n1;
      dot_mag_next    = px + py;
    end else if (px >= py) begin
      s3_next.dot_neg = n1;
      dot_mag_next    = px - py;
    end else begin
      s3_next.dot_neg = n2;
      dot_mag_next    = py - px;
    end
  end

  always_ff @(posedge clk) begin
    dot_mag <= dot_mag_next;
    norm    <= nx + ny;
    if (rst) begin
      s3 <= '0;
    end else begin
      s3 <= s3_next;
    end
  end

  // Stages 5 and 6: divisor and the dot product scaled by each difference.
  logic [DW-1:0] den;
  logic [TW-1:0] tx, ty;
  side_t         s4a, s4;

  ecol_mul #(.AW(PW), .BW(SW))  u_mul_den (.clk(clk), .a(norm), .b(s3.msum), .p(den));
  ecol_mul #(.AW(PW), .BW(DFW)) u_mul_tx (.clk(clk), .a(dot_mag), .b(s3.adx), .p(tx));
  ecol_mul #(.AW(PW), .BW(DFW)) u_mul_ty (.clk(clk), .a(dot_mag), .b(s3.ady), .p(ty));

  always_ff @(posedge clk) begin
    if (rst) begin
      s4a <= '0;
      s4  <= '0;
    end else begin
      s4a <= s3;
      s4  <= s4a;
    end
  end

  // Stages 7 and 8: numerators, scaled by twice the other particle's mass.
  logic [SW-1:0] ma2, mb2;
  logic [NW-1:0] num [NL];
  logic [DW-1:0] den5a, den5;
  side_t         s5a, s5;

  assign ma2 = {s4.ma, 1'b0};
  assign mb2 = {s4.mb, 1'b0};

  ecol_mul #(.AW(TW), .BW(SW)) u_mul_n0 (.clk(clk), .a(tx), .b(mb2), .p(num[0]));
  ecol_mul #(.AW(TW), .BW(SW)) u_mul_n1 (.clk(clk), .a(ty), .b(mb2), .p(num[1]));
  ecol_mul #(.AW(TW), .BW(SW)) u_mul_n2 (.clk(clk), .a(tx), .b(ma2), .p(num[2]));
  ecol_mul #(.AW(TW), .BW(SW)) u_mul_n3 (.clk(clk), .a(ty), .b(ma2), .p(num[3]));

  always_ff @(posedge clk) begin
    den5a <= den;
    den5  <= den5a;
    if (rst) begin
      s5a <= '0;
      s5  <= '0;
    end else begin
      s5a <= s4;
      s5  <= s5a;
    end
  end

  // Division chain. The quotient is known to stay below 2^35, so the upper
  // numerator bits are already below the divisor and seed the remainder;
  // each cell then brings down one low bit and settles one quotient bit.
  div_t chain [QW+1];

  always_comb begin
    chain[0].side = s5;
    chain[0].den  = den5;
    for (int l = 0; l < NL; l++) begin
      chain[0].rem[l] = DW'(num[l][NW-1:QW]);
      chain[0].low[l] = num[l][QW-1:0];
      chain[0].q[l]   = '0;
    end
  end

  for (genvar c = 0; c < QW; c++) begin : g_cell
    ecol_cell u_cell (.clk(clk), .rst(rst), .d_in(chain[c]), .d_out(chain[c+1]));
  end

  // Final stage: apply the signed corrections and saturate to 32 bits.
  localparam int RW = QW + 2;

  function automatic logic signed [VW-1:0] sat_add(
    input logic signed [VW-1:0] v,
    input logic [QW-1:0]        q,
    input logic                 sub
  );
    logic signed [RW-1:0] t;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] vmax;
    logic signed [RW-1:0] vmin;
    vmax = RW'({1'b0, {(VW-1){1'b1}}});
    vmin = -vmax - RW'(1);
    t = sub ? -RW'(q) : RW'(q);
    r = RW'(v) + t;
    if (r > vmax) begin
      return VW'(vmax);
    end else if (r < vmin) begin
      return VW'(vmin);
    end
    return VW'(r);
  endfunction

  div_t fin;
  logic sx_neg, sy_neg;

  assign fin    = chain[QW];
  // A term is negative when the dot product and its difference disagree in sign.
  assign sx_neg = fin.side.dot_neg ^ fin.side.neg_x;
  assign sy_neg = fin.side.dot_neg ^ fin.side.neg_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.side.valid;
    end
    coincident <= fin.side.coinc;
    if (fin.side.bypass) begin
      new_vel_ax <= fin.side.vax;
      new_vel_ay <= fin.side.vay;
      new_vel_bx <= fin.side.vbx;
      new_vel_by <= fin.side.vby;
    end else begin
      new_vel_ax <= sat_add(fin.side.vax, fin.q[0], ~sx_neg);
      new_vel_ay <= sat_add(fin.side.vay, fin.q[1], ~sy_neg);
      new_vel_bx <= sat_add(fin.side.vbx, fin.q[2], sx_neg);
      new_vel_by <= sat_add(fin.side.vby, fin.q[3], sy_neg);
    end
  end

endmodule

>>> rtl/ecol_mul.sv
// Two-stage unsigned multiplier built from partial products of 32-bit slices of a.
module ecol_mul import ecol_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int CW = 32;
  localparam int NC = (AW + CW - 1) / CW;
  localparam int RW = AW + BW;

  logic [NC*CW-1:0]   a_ext;
  logic [CW+BW-1:0]   pp [NC];
  logic [RW-1:0]      sum;

  assign a_ext = (NC*CW)'(a);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NC; i++) begin
      pp[i] <= a_ext[i*CW +: CW] * b;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NC; i++) begin
      sum = sum + (RW'(pp[i]) << (i * CW));
    end
  end

  always_ff @(posedge clk) begin
    p <= sum;
  end

endmodule

>>> rtl/ecol_cell.sv
// One restoring-division step for all four correction terms of an item.
module ecol_cell import ecol_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_t d_in,
  output div_t d_out
);

  div_t       nxt;
  logic [DW:0] r2;
  logic        ge;

  always_comb begin
    nxt = d_in;
    r2  = '0;
    ge  = 1'b0;
    for (int l = 0; l < NL; l++) begin
      r2 = {d_in.rem[l], d_in.low[l][QW-1]};
      ge = (r2 >= {1'b0, d_in.den});
      nxt.rem[l] = ge ? DW'(r2 - {1'b0, d_in.den}) : DW'(r2);
      nxt.low[l] = d_in.low[l] << 1;
      nxt.q[l]   = {d_in.q[l][QW-2:0], ge};
    end
    // Reset empties the cell by dropping its valid flag.
    nxt.side.valid = d_in.side.valid & ~rst;
  end

  always_ff @(posedge clk) begin
    d_out <= nxt;
  end

endmodule
